// ----- rtl/core/wdcs_pkg.sv -----
// Shared types and constants for the wet/dry crossfade switcher.
// No dependencies; imported by every module of the block.
`default_nettype none

package wdcs_pkg;

    localparam int GAIN_W    = 24;
    localparam int FRAC_BITS = 23;
    localparam int EFF_W     = 3;
    localparam int APB_AW    = 3;
    localparam int APB_DW    = 32;

    localparam logic [GAIN_W-1:0] GAIN_ONE = 24'h800000;
    localparam logic [GAIN_W-1:0] HALF_LSB = 24'h400000;

    localparam logic [GAIN_W-1:0] WET_STEP_RST     = 24'd17476;
    localparam logic [GAIN_W-1:0] THERMAL_STEP_RST = 24'd8738;

    localparam logic [APB_AW-1:0] ADDR_WET_STEP     = 3'd0;
    localparam logic [APB_AW-1:0] ADDR_THERMAL_STEP = 3'd4;

    localparam logic [EFF_W-1:0] EFF_TUNER = 3'd0;

    typedef enum logic [1:0] {
        FADE_STEADY = 2'd0,
        FADE_OUT    = 2'd1,
        FADE_IN     = 2'd2
    } t_fade;

    typedef enum logic [1:0] {
        HEAT_NORMAL = 2'd0,
        HEAT_FADING = 2'd1,
        HEAT_MUTED  = 2'd2
    } t_heat;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MIX_L,
        ST_MIX_R,
        ST_SCALE_L,
        ST_SCALE_R,
        ST_DONE
    } t_state;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_MIX_L,
        OP_MIX_R,
        OP_SCALE_L,
        OP_SCALE_R
    } t_mul_op;

    typedef struct packed {
        logic    load;
        t_mul_op op;
        logic    commit;
    } t_dp_cmd;

endpackage

`default_nettype wire

// ----- rtl/core/wet_dry_crossfade_switcher.sv -----
// Wet/dry crossfade switcher with thermal fade-out: top level.
// Holds the APB register file and ties wdcs_ctrl to wdcs_dp; uses wdcs_pkg.
//
// Usage:
//  - s_axis carries one item per transfer. tuser is the item kind (0 sample,
//    1 control). A sample yields a clamped, thermally scaled stereo mix; a
//    control item requests an effect/bypass setting or a thermal shutdown.
//  - m_axis returns exactly one result per accepted item, in order.
//  - A sample steps the shared 25x25 gain multiplier through its products (two
//    wet-gain products, two thermal products), then the result state; the
//    next item is taken only after that, so items never overlap. A control
//    item goes straight from accept to the result state.
//  - The output register holds a finished result while the next item is
//    taken and computed; if the receiver stalls, the block waits in the
//    result cycle and s_axis_tready stays low until the register frees.
//  - APB: wet_step at 0x0, thermal_step at 0x4; write only while idle.
//  - Synchronous reset restores unity thermal gain, tuner selected, zero
//    wet gain and the default step values; no clearing pass is needed.
`default_nettype none

module wet_dry_crossfade_switcher
    import wdcs_pkg::*;
#(
    parameter int NUM_EFFECTS = 5,
    parameter int SAMPLE_BITS = 24
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    // dry_sample, wet_left, wet_right, effect_req, bypass_req,
    // thermal_shutdown (lowest bits first), zero padded to bytes
    input  wire logic [((3*SAMPLE_BITS+5+7)/8)*8-1:0] s_axis_tdata,
    // mode
    input  wire logic                    s_axis_tuser,
    input  wire logic                    s_axis_tvalid,
    output logic                         s_axis_tready,
    // left_out, right_out, effect_enable, active_effect, active_bypass,
    // fade_state, thermal_state (lowest bits first), zero padded to bytes
    output logic [((2*SAMPLE_BITS+9+7)/8)*8-1:0] m_axis_tdata,
    output logic                         m_axis_tvalid,
    input  wire logic                    m_axis_tready,
    input  wire logic                    psel,
    input  wire logic                    penable,
    input  wire logic                    pwrite,
    input  wire logic [APB_AW-1:0]       paddr,
    input  wire logic [APB_DW-1:0]       pwdata,
    output logic [APB_DW-1:0]            prdata,
    output logic                         pready
);

    localparam int SB        = SAMPLE_BITS;
    localparam int OUT_USED  = 2 * SB + 9;
    localparam int OUT_W     = ((OUT_USED + 7) / 8) * 8;

    logic [GAIN_W-1:0] r_wet_step;
    logic [GAIN_W-1:0] r_thermal_step;
    logic              w_wr;

    t_dp_cmd              w_cmd;
    logic signed [SB-1:0] w_left;
    logic signed [SB-1:0] w_right;
    logic                 w_en;
    logic [EFF_W-1:0]     w_eff;
    logic                 w_byp;
    logic [1:0]           w_fade;
    logic [1:0]           w_heat;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wet_step     <= WET_STEP_RST;
            r_thermal_step <= THERMAL_STEP_RST;
        end else if (w_wr) begin
            if (paddr == ADDR_WET_STEP) begin
                r_wet_step <= pwdata[GAIN_W-1:0];
            end
            if (paddr == ADDR_THERMAL_STEP) begin
                r_thermal_step <= pwdata[GAIN_W-1:0];
            end
        end
    end

    always_comb begin
        unique case (paddr)
            ADDR_WET_STEP:     prdata = {{(APB_DW - GAIN_W){1'b0}}, r_wet_step};
            ADDR_THERMAL_STEP: prdata = {{(APB_DW - GAIN_W){1'b0}}, r_thermal_step};
            default:           prdata = '0;
        endcase
    end

    wdcs_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (s_axis_tvalid),
        .i_s_mode  (s_axis_tuser),
        .o_s_ready (s_axis_tready),
        .i_m_ready (m_axis_tready),
        .o_m_valid (m_axis_tvalid),
        .o_cmd     (w_cmd)
    );

    wdcs_dp #(
        .NUM_EFFECTS (NUM_EFFECTS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .i_mode         (s_axis_tuser),
        .i_dry          (s_axis_tdata[SB-1:0]),
        .i_wet_l        (s_axis_tdata[2*SB-1:SB]),
        .i_wet_r        (s_axis_tdata[3*SB-1:2*SB]),
        .i_req_eff      (s_axis_tdata[3*SB+2:3*SB]),
        .i_req_byp      (s_axis_tdata[3*SB+3]),
        .i_shut         (s_axis_tdata[3*SB+4]),
        .i_wet_step     (r_wet_step),
        .i_thermal_step (r_thermal_step),
        .o_left         (w_left),
        .o_right        (w_right),
        .o_en           (w_en),
        .o_eff          (w_eff),
        .o_byp          (w_byp),
        .o_fade         (w_fade),
        .o_heat         (w_heat)
    );

    assign m_axis_tdata = {{(OUT_W - OUT_USED){1'b0}}, w_heat, w_fade, w_byp, w_eff, w_en,
                           w_right, w_left};

endmodule

`default_nettype wire

// ----- rtl/core/wdcs_ctrl.sv -----
// Sequencer for the switcher: steps the shared multiplier through one item
// and owns the output valid flag. Depends on wdcs_pkg.
`default_nettype none

module wdcs_ctrl
    import wdcs_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_s_valid,
    input  wire logic    i_s_mode,
    output logic         o_s_ready,
    input  wire logic    i_m_ready,
    output logic         o_m_valid,
    output t_dp_cmd      o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   w_out_free;
    logic   w_accept;

    assign w_out_free = !r_out_valid || i_m_ready;
    assign w_accept   = i_s_valid && (r_state == ST_IDLE);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_s_valid) begin
                    n_state = i_s_mode ? ST_DONE : ST_MIX_L;
                end
            end
            ST_MIX_L:   n_state = ST_MIX_R;
            ST_MIX_R:   n_state = ST_SCALE_L;
            ST_SCALE_L: n_state = ST_SCALE_R;
            ST_SCALE_R: n_state = ST_DONE;
            ST_DONE: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default:    n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_s_ready   = 1'b0;
        o_cmd.load  = 1'b0;
        o_cmd.op    = OP_NONE;
        o_cmd.commit = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_s_ready  = 1'b1;
                o_cmd.load = i_s_valid;
            end
            ST_MIX_L:   o_cmd.op = OP_MIX_L;
            ST_MIX_R:   o_cmd.op = OP_MIX_R;
            ST_SCALE_L: o_cmd.op = OP_SCALE_L;
            ST_SCALE_R: o_cmd.op = OP_SCALE_R;
            ST_DONE:    o_cmd.commit = w_out_free;
            default:    o_cmd.op = OP_NONE;
        endcase
    end

    always_comb begin
        if (o_cmd.commit) begin
            n_out_valid = 1'b1;
        end else begin
            n_out_valid = r_out_valid && !i_m_ready;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_m_valid = r_out_valid;

    a_commit_into_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.commit |-> (!r_out_valid || i_m_ready))
        else $error("result committed over an untaken transfer");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state != ST_IDLE))
        else $error("sequencer stayed idle after accepting an item");

    a_scale_to_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCALE_R) |=> (r_state == ST_DONE))
        else $error("sample path skipped the result stage");

endmodule

`default_nettype wire

// ----- rtl/core/wdcs_dp.sv -----
// Datapath: input capture, shared gain multiplier with rounding and clamp,
// switch/fade/thermal state and the output register. Depends on wdcs_pkg.
`default_nettype none

module wdcs_dp
    import wdcs_pkg::*;
#(
    parameter int NUM_EFFECTS = 5,
    parameter int SAMPLE_BITS = 24
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire t_dp_cmd                       i_cmd,
    input  wire logic                          i_mode,
    input  wire logic signed [SAMPLE_BITS-1:0] i_dry,
    input  wire logic signed [SAMPLE_BITS-1:0] i_wet_l,
    input  wire logic signed [SAMPLE_BITS-1:0] i_wet_r,
    input  wire logic [EFF_W-1:0]              i_req_eff,
    input  wire logic                          i_req_byp,
    input  wire logic                          i_shut,
    input  wire logic [GAIN_W-1:0]             i_wet_step,
    input  wire logic [GAIN_W-1:0]             i_thermal_step,
    output logic signed [SAMPLE_BITS-1:0]      o_left,
    output logic signed [SAMPLE_BITS-1:0]      o_right,
    output logic                               o_en,
    output logic [EFF_W-1:0]                   o_eff,
    output logic                               o_byp,
    output logic [1:0]                         o_fade,
    output logic [1:0]                         o_heat
);

    localparam int SB = SAMPLE_BITS;
    localparam int DW = SB + 1;
    localparam int PW = DW + GAIN_W + 1;
    localparam longint unsigned LIM_U = (64'd95 * (64'd1 << (SB - 1)) + 64'd50) / 64'd100;
    localparam logic signed [SB+1:0] LIM_P  = (SB + 2)'(LIM_U);
    localparam logic signed [PW-1:0] HALF_P = PW'(HALF_LSB);

    // captured item
    logic                 r_is_ctrl;
    logic signed [SB-1:0] r_x;
    logic signed [DW-1:0] r_dl;
    logic signed [DW-1:0] r_dr;
    logic                 r_en;
    logic [EFF_W-1:0]     r_req_eff;
    logic                 r_req_byp;
    logic                 r_shut;

    // arithmetic pipeline
    logic signed [PW-1:0] r_prod;
    logic signed [SB-1:0] r_ml;
    logic signed [SB-1:0] r_mr;
    logic signed [SB-1:0] r_left;

    // switch state
    logic [GAIN_W-1:0] r_wg,      n_wg;
    logic [GAIN_W-1:0] r_tg,      n_tg;
    logic [EFF_W-1:0]  r_cur_eff, n_cur_eff;
    logic              r_cur_byp, n_cur_byp;
    logic [EFF_W-1:0]  r_nxt_eff, n_nxt_eff;
    logic              r_nxt_byp, n_nxt_byp;
    t_fade             r_fade,    n_fade;
    t_heat             r_heat,    n_heat;

    // output register
    logic signed [SB-1:0] r_o_left;
    logic signed [SB-1:0] r_o_right;
    logic                 r_o_en;
    logic [EFF_W-1:0]     r_o_eff;
    logic                 r_o_byp;
    t_fade                r_o_fade;
    t_heat                r_o_heat;

    logic                   w_live_now;
    logic                   w_cur_live;
    logic                   w_eff_oob;
    logic signed [DW-1:0]   w_a;
    logic signed [GAIN_W:0] w_b;
    logic signed [PW-1:0]   w_sum;
    logic signed [PW-1:0]   w_shr;
    logic signed [DW-1:0]   w_rnd;
    logic signed [SB+1:0]   w_mix;
    logic signed [SB+1:0]   w_clamp;
    logic [GAIN_W:0]        w_wsum;
    logic                   w_zero;

    assign w_live_now = (r_cur_eff != EFF_TUNER) && !(r_cur_byp && (r_fade == FADE_STEADY));
    assign w_cur_live = (r_cur_eff != EFF_TUNER) && !r_cur_byp;
    assign w_eff_oob  = {1'b0, i_req_eff} >= (EFF_W + 1)'(NUM_EFFECTS);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_is_ctrl <= i_mode;
            r_x       <= i_dry;
            r_en      <= w_live_now;
            r_dl      <= w_live_now ? ({i_wet_l[SB-1], i_wet_l} - {i_dry[SB-1], i_dry})
                                    : '0;
            r_dr      <= w_live_now ? ({i_wet_r[SB-1], i_wet_r} - {i_dry[SB-1], i_dry})
                                    : '0;
            r_req_eff <= w_eff_oob ? EFF_TUNER : i_req_eff;
            r_req_byp <= i_req_byp;
            r_shut    <= i_shut;
        end
    end

    always_comb begin
        unique case (i_cmd.op)
            OP_MIX_L: begin
                w_a = r_dl;
                w_b = {1'b0, r_wg};
            end
            OP_MIX_R: begin
                w_a = r_dr;
                w_b = {1'b0, r_wg};
            end
            OP_SCALE_L: begin
                w_a = {r_ml[SB-1], r_ml};
                w_b = {1'b0, r_tg};
            end
            OP_SCALE_R: begin
                w_a = {r_mr[SB-1], r_mr};
                w_b = {1'b0, r_tg};
            end
            default: begin
                w_a = '0;
                w_b = '0;
            end
        endcase
    end

    // round to nearest, ties up: floor((p + half) / 2^23)
    assign w_sum = r_prod + HALF_P;
    assign w_shr = w_sum >>> FRAC_BITS;
    assign w_rnd = w_shr[DW-1:0];
    assign w_mix = {{2{r_x[SB-1]}}, r_x} + {w_rnd[DW-1], w_rnd};

    always_comb begin
        if (w_mix > LIM_P) begin
            w_clamp = LIM_P;
        end else if (w_mix < -LIM_P) begin
            w_clamp = -LIM_P;
        end else begin
            w_clamp = w_mix;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op != OP_NONE) begin
            r_prod <= w_a * w_b;
        end
        if (i_cmd.op == OP_MIX_R) begin
            r_ml <= w_clamp[SB-1:0];
        end
        if (i_cmd.op == OP_SCALE_L) begin
            r_mr <= w_clamp[SB-1:0];
        end
        if (i_cmd.op == OP_SCALE_R) begin
            r_left <= w_rnd[SB-1:0];
        end
    end

    assign w_wsum = {1'b0, r_wg} + {1'b0, i_wet_step};
    assign w_zero = r_is_ctrl || (r_heat == HEAT_MUTED);

    always_comb begin
        n_wg      = r_wg;
        n_tg      = r_tg;
        n_cur_eff = r_cur_eff;
        n_cur_byp = r_cur_byp;
        n_nxt_eff = r_nxt_eff;
        n_nxt_byp = r_nxt_byp;
        n_fade    = r_fade;
        n_heat    = r_heat;
        if (i_cmd.commit) begin
            if (r_is_ctrl) begin
                if (r_shut) begin
                    if (r_heat == HEAT_NORMAL) begin
                        n_heat = HEAT_FADING;
                        n_tg   = GAIN_ONE;
                    end
                end else if (r_heat == HEAT_NORMAL) begin
                    if ((r_req_eff != r_nxt_eff) || (r_req_byp != r_nxt_byp)) begin
                        n_nxt_eff = r_req_eff;
                        n_nxt_byp = r_req_byp;
                        if ((r_wg != '0) && w_cur_live) begin
                            n_fade = FADE_OUT;
                        end else begin
                            n_cur_eff = r_req_eff;
                            n_cur_byp = r_req_byp;
                            n_wg      = '0;
                            n_fade    = ((r_req_eff != EFF_TUNER) && !r_req_byp) ? FADE_IN
                                                                                 : FADE_STEADY;
                        end
                    end
                end
            end else if (r_heat == HEAT_FADING) begin
                if (i_thermal_step >= r_tg) begin
                    n_tg   = '0;
                    n_heat = HEAT_MUTED;
                end else begin
                    n_tg = r_tg - i_thermal_step;
                end
            end else if (r_heat == HEAT_NORMAL) begin
                if (r_fade == FADE_OUT) begin
                    if (i_wet_step >= r_wg) begin
                        n_cur_eff = r_nxt_eff;
                        n_cur_byp = r_nxt_byp;
                        n_wg      = '0;
                        n_fade    = ((r_nxt_eff != EFF_TUNER) && !r_nxt_byp) ? FADE_IN
                                                                             : FADE_STEADY;
                    end else begin
                        n_wg = r_wg - i_wet_step;
                    end
                end else if (r_fade == FADE_IN) begin
                    if (w_wsum >= {1'b0, GAIN_ONE}) begin
                        n_wg   = GAIN_ONE;
                        n_fade = FADE_STEADY;
                    end else begin
                        n_wg = w_wsum[GAIN_W-1:0];
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wg      <= '0;
            r_tg      <= GAIN_ONE;
            r_cur_eff <= EFF_TUNER;
            r_cur_byp <= 1'b0;
            r_nxt_eff <= EFF_TUNER;
            r_nxt_byp <= 1'b0;
            r_fade    <= FADE_STEADY;
            r_heat    <= HEAT_NORMAL;
        end else begin
            r_wg      <= n_wg;
            r_tg      <= n_tg;
            r_cur_eff <= n_cur_eff;
            r_cur_byp <= n_cur_byp;
            r_nxt_eff <= n_nxt_eff;
            r_nxt_byp <= n_nxt_byp;
            r_fade    <= n_fade;
            r_heat    <= n_heat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_o_left  <= w_zero ? '0 : r_left;
            r_o_right <= w_zero ? '0 : w_rnd[SB-1:0];
            r_o_en    <= w_zero ? 1'b0 : r_en;
            r_o_eff   <= n_cur_eff;
            r_o_byp   <= n_cur_byp;
            r_o_fade  <= n_fade;
            r_o_heat  <= n_heat;
        end
    end

    assign o_left  = r_o_left;
    assign o_right = r_o_right;
    assign o_en    = r_o_en;
    assign o_eff   = r_o_eff;
    assign o_byp   = r_o_byp;
    assign o_fade  = r_o_fade;
    assign o_heat  = r_o_heat;

    a_wet_gain_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wg <= GAIN_ONE)
        else $error("wet gain above unity");

    a_muted_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_heat == HEAT_MUTED) |-> (r_tg == '0))
        else $error("muted with nonzero thermal gain");

    a_fade_in_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fade == FADE_IN) |-> ((r_cur_eff != EFF_TUNER) && !r_cur_byp))
        else $error("fading in toward a dry setting");

endmodule

`default_nettype wire
